// ===== hdl/css_pkg.sv =====
// ----------------------------------------------------------------------------
// css_pkg
// Shared types and constants for the comment stripper stream.
// ----------------------------------------------------------------------------
package css_pkg;

    // input request codes
    localparam logic CMD_TEXT = 1'b0;
    localparam logic CMD_EOL  = 1'b1;

    // result kinds
    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOL  = 1'b1;

    // characters
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;

    // line phase
    localparam logic [1:0] PH_LEAD   = 2'd0;
    localparam logic [1:0] PH_NORMAL = 2'd1;
    localparam logic [1:0] PH_AFTER2 = 2'd2;
    localparam logic [1:0] PH_DROP   = 2'd3;

    typedef struct packed {
        logic accept;
        logic emit_lead;
        logic emit_slash;
        logic emit_final;
    } css_cmd_t;

    typedef struct packed {
        logic lead_pend;
        logic slash_pend;
        logic final_pend;
        logic slot_free;
    } css_status_t;

endpackage

// ===== hdl/css_text_if.sv =====
// ----------------------------------------------------------------------------
// css_text_if
// Input channel: one text byte or end-of-line request.
// ----------------------------------------------------------------------------
interface css_text_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] text_byte;

    modport source (output valid, output cmd, output text_byte, input ready);
    modport sink   (input valid, input cmd, input text_byte, output ready);
endinterface

// ===== hdl/css_result_if.sv =====
// ----------------------------------------------------------------------------
// css_result_if
// Output channel: kept bytes and end-of-line markers.
// ----------------------------------------------------------------------------
interface css_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       kind;
    logic       continued;
    logic       comment_open;
    logic       lead_overflow;
    logic       last;

    modport source (output valid, output out_byte, output kind, output continued,
                    output comment_open, output lead_overflow, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input kind, input continued,
                    input comment_open, input lead_overflow, input last,
                    output ready);
endinterface

// ===== hdl/css_ctrl.sv =====
// ----------------------------------------------------------------------------
// css_ctrl
// Sequencer: accepts requests and drains the pending results of each one.
// ----------------------------------------------------------------------------
module css_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  css_pkg::css_status_t  status,
    output css_pkg::css_cmd_t     cmd
);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next     = state_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            ST_DRAIN:
            begin
                if (status.lead_pend)
                begin
                    cmd.emit_lead = status.slot_free;
                end
                else if (status.slash_pend)
                begin
                    cmd.emit_slash = status.slot_free;
                end
                else
                begin
                    in_ready       = !status.final_pend || status.slot_free;
                    cmd.emit_final = status.final_pend && status.slot_free;
                    if (in_ready)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        cmd.accept = in_ready && in_valid;
        if (cmd.accept)
        begin
            state_next = ST_DRAIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/css_datapath.sv =====
// ----------------------------------------------------------------------------
// css_datapath
// Parse state, lead blank store, pending result plan and output register.
// ----------------------------------------------------------------------------
module css_datapath
#(
    parameter int MAX_LEAD = 63
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  css_pkg::css_cmd_t     cmd,
    output css_pkg::css_status_t  status,
    input  logic                  in_cmd,
    input  logic [7:0]            in_byte,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [7:0]            out_byte,
    output logic                  out_kind,
    output logic                  out_continued,
    output logic                  out_comment_open,
    output logic                  out_lead_overflow,
    output logic                  out_last
);

    localparam int CW = $clog2(MAX_LEAD + 1);
    localparam int AW = (MAX_LEAD > 1) ? $clog2(MAX_LEAD) : 1;
    localparam logic [CW-1:0] LEAD_MAX = CW'(MAX_LEAD);

    // parse state
    logic          in_block_reg,    in_block_next;
    logic          star_seen_reg,   star_seen_next;
    logic          in_quote_reg,    in_quote_next;
    logic [1:0]    phase_reg,       phase_next;
    logic          slash_held_reg,  slash_held_next;
    logic          slash_ok_reg,    slash_ok_next;
    logic          prev_blank_reg,  prev_blank_next;
    logic          cont_reg,        cont_next;
    logic [CW-1:0] lead_count_reg,  lead_count_next;
    logic          ovf_reg,         ovf_next;

    // result plan of the last request
    logic [CW-1:0] plan_lead_n_reg, plan_lead_n_next;
    logic          plan_slash_reg,  plan_slash_next;
    logic          plan_final_reg,  plan_final_next;
    logic [7:0]    plan_byte_reg,   plan_byte_next;
    logic          plan_kind_reg,   plan_kind_next;
    logic          plan_cont_reg,   plan_cont_next;
    logic          plan_open_reg,   plan_open_next;
    logic          plan_ovf_reg,    plan_ovf_next;
    logic [CW-1:0] rel_idx_reg;
    logic [CW-1:0] rel_idx_next;

    // lead blank store (1 = tab)
    logic          lead_mem [MAX_LEAD];
    logic          lead_wr;
    logic          rd_data_reg;
    logic [AW-1:0] rd_addr;

    // output register
    logic          out_valid_reg;
    logic [7:0]    out_byte_reg;
    logic          out_kind_reg;
    logic          out_cont_reg;
    logic          out_open_reg;
    logic          out_ovf_reg;
    logic          out_last_reg;

    logic          blank;
    logic          pb;
    logic          go;
    logic          plain;
    logic          lead_last;

    assign blank = (in_byte == css_pkg::CH_SPACE) || (in_byte == css_pkg::CH_TAB);

    always_comb
    begin
        in_block_next    = in_block_reg;
        star_seen_next   = star_seen_reg;
        in_quote_next    = in_quote_reg;
        phase_next       = phase_reg;
        slash_held_next  = slash_held_reg;
        slash_ok_next    = slash_ok_reg;
        cont_next        = cont_reg;
        lead_count_next  = lead_count_reg;
        ovf_next         = ovf_reg;
        pb               = prev_blank_reg;
        go               = 1'b0;
        plain            = 1'b0;
        lead_wr          = 1'b0;
        plan_lead_n_next = '0;
        plan_slash_next  = 1'b0;
        plan_final_next  = 1'b0;
        plan_byte_next   = in_byte;
        plan_kind_next   = css_pkg::KIND_BYTE;
        plan_cont_next   = 1'b0;
        plan_open_next   = 1'b0;
        plan_ovf_next    = 1'b0;

        if (in_cmd == css_pkg::CMD_EOL)
        begin
            if (!in_block_reg)
            begin
                if (phase_reg == css_pkg::PH_LEAD)
                begin
                    plan_lead_n_next = lead_count_reg;
                end
                if (phase_reg == css_pkg::PH_NORMAL && slash_held_reg)
                begin
                    plan_slash_next = 1'b1;
                end
            end
            plan_final_next = 1'b1;
            plan_byte_next  = 8'h00;
            plan_kind_next  = css_pkg::KIND_EOL;
            plan_cont_next  = cont_reg;
            plan_open_next  = in_block_reg;
            plan_ovf_next   = ovf_reg;
            in_quote_next   = 1'b0;
            star_seen_next  = 1'b0;
            slash_held_next = 1'b0;
            slash_ok_next   = 1'b0;
            pb              = 1'b1;
            cont_next       = 1'b0;
            lead_count_next = '0;
            ovf_next        = 1'b0;
            phase_next      = css_pkg::PH_LEAD;
        end
        else if (in_block_reg)
        begin
            if (star_seen_reg && in_byte == css_pkg::CH_SLASH)
            begin
                in_block_next  = 1'b0;
                star_seen_next = 1'b0;
                phase_next     = css_pkg::PH_NORMAL;
            end
            else
            begin
                star_seen_next = (in_byte == css_pkg::CH_STAR);
            end
            pb = blank;
        end
        else if (phase_reg == css_pkg::PH_DROP)
        begin
            go = 1'b0;
        end
        else if (phase_reg == css_pkg::PH_AFTER2)
        begin
            if (in_byte == css_pkg::CH_SLASH)
            begin
                cont_next = 1'b1;
            end
            phase_next = css_pkg::PH_DROP;
        end
        else
        begin
            go = 1'b1;
            if (phase_reg == css_pkg::PH_LEAD)
            begin
                if (blank)
                begin
                    if (lead_count_reg < LEAD_MAX)
                    begin
                        lead_wr         = 1'b1;
                        lead_count_next = lead_count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    pb = 1'b1;
                    go = 1'b0;
                end
                else if (in_byte == css_pkg::CH_STAR)
                begin
                    lead_count_next = '0;
                    phase_next      = css_pkg::PH_DROP;
                    go              = 1'b0;
                end
                else
                begin
                    plan_lead_n_next = lead_count_reg;
                    lead_count_next  = '0;
                    phase_next       = css_pkg::PH_NORMAL;
                end
            end
            if (go)
            begin
                if (in_quote_reg)
                begin
                    plan_final_next = 1'b1;
                    if (in_byte == css_pkg::CH_QUOTE)
                    begin
                        in_quote_next = 1'b0;
                    end
                    pb = blank;
                end
                else
                begin
                    plain = 1'b1;
                    if (slash_held_reg)
                    begin
                        if (in_byte == css_pkg::CH_STAR)
                        begin
                            slash_held_next = 1'b0;
                            in_block_next   = 1'b1;
                            star_seen_next  = 1'b0;
                            pb              = 1'b0;
                            plain           = 1'b0;
                        end
                        else if (in_byte == css_pkg::CH_SLASH)
                        begin
                            if (slash_ok_reg)
                            begin
                                slash_held_next = 1'b0;
                                phase_next      = css_pkg::PH_AFTER2;
                            end
                            else
                            begin
                                plan_slash_next = 1'b1;
                                slash_ok_next   = 1'b0;
                            end
                            pb    = 1'b0;
                            plain = 1'b0;
                        end
                        else
                        begin
                            plan_slash_next = 1'b1;
                            slash_held_next = 1'b0;
                            pb              = 1'b0;
                        end
                    end
                    if (plain)
                    begin
                        if (in_byte == css_pkg::CH_QUOTE)
                        begin
                            plan_final_next = 1'b1;
                            in_quote_next   = 1'b1;
                        end
                        else if (in_byte == css_pkg::CH_SLASH)
                        begin
                            slash_held_next = 1'b1;
                            slash_ok_next   = pb;
                        end
                        else
                        begin
                            plan_final_next = 1'b1;
                        end
                        pb = blank;
                    end
                end
            end
        end
        prev_blank_next = pb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_block_reg   <= 1'b0;
            star_seen_reg  <= 1'b0;
            in_quote_reg   <= 1'b0;
            phase_reg      <= css_pkg::PH_LEAD;
            slash_held_reg <= 1'b0;
            slash_ok_reg   <= 1'b0;
            prev_blank_reg <= 1'b1;
            cont_reg       <= 1'b0;
            lead_count_reg <= '0;
            ovf_reg        <= 1'b0;
        end
        else if (cmd.accept)
        begin
            in_block_reg   <= in_block_next;
            star_seen_reg  <= star_seen_next;
            in_quote_reg   <= in_quote_next;
            phase_reg      <= phase_next;
            slash_held_reg <= slash_held_next;
            slash_ok_reg   <= slash_ok_next;
            prev_blank_reg <= prev_blank_next;
            cont_reg       <= cont_next;
            lead_count_reg <= lead_count_next;
            ovf_reg        <= ovf_next;
        end
    end

    // plan control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plan_lead_n_reg <= '0;
            plan_slash_reg  <= 1'b0;
            plan_final_reg  <= 1'b0;
            rel_idx_reg     <= '0;
        end
        else
        begin
            rel_idx_reg <= rel_idx_next;
            if (cmd.accept)
            begin
                plan_lead_n_reg <= plan_lead_n_next;
                plan_slash_reg  <= plan_slash_next;
                plan_final_reg  <= plan_final_next;
            end
            else
            begin
                if (cmd.emit_slash)
                begin
                    plan_slash_reg <= 1'b0;
                end
                if (cmd.emit_final)
                begin
                    plan_final_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            plan_byte_reg <= plan_byte_next;
            plan_kind_reg <= plan_kind_next;
            plan_cont_reg <= plan_cont_next;
            plan_open_reg <= plan_open_next;
            plan_ovf_reg  <= plan_ovf_next;
        end
    end

    always_comb
    begin
        if (cmd.accept)
        begin
            rel_idx_next = '0;
        end
        else if (cmd.emit_lead)
        begin
            rel_idx_next = rel_idx_reg + 1'b1;
        end
        else
        begin
            rel_idx_next = rel_idx_reg;
        end
        rd_addr = (rel_idx_next < LEAD_MAX) ? rel_idx_next[AW-1:0] : '0;
    end

    // lead store: write on a held blank, read one entry ahead of release
    always_ff @(posedge clk)
    begin
        if (cmd.accept && lead_wr)
        begin
            lead_mem[lead_count_reg[AW-1:0]] <= (in_byte == css_pkg::CH_TAB);
        end
        rd_data_reg <= lead_mem[rd_addr];
    end

    assign lead_last = ((rel_idx_reg + 1'b1) == plan_lead_n_reg)
                       && !plan_slash_reg && !plan_final_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit_lead || cmd.emit_slash || cmd.emit_final)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_lead)
        begin
            out_byte_reg <= rd_data_reg ? css_pkg::CH_TAB : css_pkg::CH_SPACE;
            out_kind_reg <= css_pkg::KIND_BYTE;
            out_cont_reg <= 1'b0;
            out_open_reg <= 1'b0;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= lead_last;
        end
        else if (cmd.emit_slash)
        begin
            out_byte_reg <= css_pkg::CH_SLASH;
            out_kind_reg <= css_pkg::KIND_BYTE;
            out_cont_reg <= 1'b0;
            out_open_reg <= 1'b0;
            out_ovf_reg  <= 1'b0;
            out_last_reg <= !plan_final_reg;
        end
        else if (cmd.emit_final)
        begin
            out_byte_reg <= plan_byte_reg;
            out_kind_reg <= plan_kind_reg;
            out_cont_reg <= plan_cont_reg;
            out_open_reg <= plan_open_reg;
            out_ovf_reg  <= plan_ovf_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign status.lead_pend  = (rel_idx_reg != plan_lead_n_reg);
    assign status.slash_pend = plan_slash_reg;
    assign status.final_pend = plan_final_reg;
    assign status.slot_free  = !out_valid_reg || out_ready;

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign out_kind          = out_kind_reg;
    assign out_continued     = out_cont_reg;
    assign out_comment_open  = out_open_reg;
    assign out_lead_overflow = out_ovf_reg;
    assign out_last          = out_last_reg;

endmodule

// ===== hdl/comment_stripper_stream.sv =====
// ----------------------------------------------------------------------------
// comment_stripper_stream
// Streams source text through and removes block, line and star-line comments.
// ----------------------------------------------------------------------------
// Usage:
//   text_ch carries one request per beat: cmd = 0 with a text byte, or
//   cmd = 1 to end the current line. result_ch returns kept bytes (kind 0)
//   and one end-of-line marker per line (kind 1) carrying the continued,
//   comment_open and lead_overflow flags; last marks the final result of
//   each request.
//   A taken request is registered in the result plan, from which each result
//   moves on to the output register. A request giving at most one result is
//   taken every cycle while the receiver keeps up. Leading blanks are held in
//   a MAX_LEAD-entry store until the first non-blank byte; they are released
//   one blank per cycle from the store's read port while the receiver keeps
//   up, with text_ch held off. A pending slash is released after them, likewise.
//   When result_ch stalls the output register holds and text_ch stops once
//   the next result has nowhere to go.
//   Reset clears all line and comment state and empties the output register;
//   the blank store needs no clearing.
// ----------------------------------------------------------------------------
module comment_stripper_stream
#(
    parameter int MAX_LEAD = 63
)
(
    input  logic                clk,
    input  logic                rst_n,
    css_text_if.sink            text_ch,
    css_result_if.source        result_ch
);

    css_pkg::css_cmd_t    cmd;
    css_pkg::css_status_t status;

    css_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (text_ch.valid),
        .in_ready (text_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    css_datapath
    #(
        .MAX_LEAD (MAX_LEAD)
    )
    u_datapath
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .in_cmd            (text_ch.cmd),
        .in_byte           (text_ch.text_byte),
        .out_ready         (result_ch.ready),
        .out_valid         (result_ch.valid),
        .out_byte          (result_ch.out_byte),
        .out_kind          (result_ch.kind),
        .out_continued     (result_ch.continued),
        .out_comment_open  (result_ch.comment_open),
        .out_lead_overflow (result_ch.lead_overflow),
        .out_last          (result_ch.last)
    );

endmodule

// ===== hdl/css_checker.sv =====
// ----------------------------------------------------------------------------
// css_checker
// Port-level checks on the result channel of the comment stripper.
// ----------------------------------------------------------------------------
module css_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic [7:0] out_byte,
    input  logic       kind,
    input  logic       continued,
    input  logic       comment_open,
    input  logic       lead_overflow,
    input  logic       last
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(kind)
                                    && $stable(last))
        else $error("result changed while stalled");

    a_marker_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == css_pkg::KIND_EOL |-> last)
        else $error("end-of-line marker not last of its request");

    a_marker_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == css_pkg::KIND_EOL |-> out_byte == 8'h00)
        else $error("end-of-line marker carries a byte");

    a_byte_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == css_pkg::KIND_BYTE
            |-> !continued && !comment_open && !lead_overflow)
        else $error("line flags set on a kept byte");

endmodule

bind comment_stripper_stream css_checker u_css_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (result_ch.valid),
    .out_ready     (result_ch.ready),
    .out_byte      (result_ch.out_byte),
    .kind          (result_ch.kind),
    .continued     (result_ch.continued),
    .comment_open  (result_ch.comment_open),
    .lead_overflow (result_ch.lead_overflow),
    .last          (result_ch.last)
);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for comment_stripper_stream. A scripted run of short
// lines covers the comment, string, star-line and blank-handling cases, then
// random lines built from comment and string fragments (with some raw noise)
// follow. Every accepted request is predicted in-bench and each result is
// checked in order against the prediction, with random idling on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int LEAD_DEPTH  = 63;
    localparam int RES_CAP     = 64;
    localparam int TAIL_CYCLES = 80;
    localparam int STALL_LEN   = 300;
    localparam int RAND_ITEMS  = 420;
    localparam int SCRIPT_LEN  = 30;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       kind;
        logic       continued;
        logic       comment_open;
        logic       lead_overflow;
        logic       last;
    } strip_res_t;

    // scripted request; has_res/rk..rb give the single result where typed
    typedef struct packed {
        logic       cmd;
        logic [7:0] ch;
        logic       typed;
        logic       has_res;
        logic       rk;
        logic       rc;
        logic       ro;
        logic       rv;
        logic [7:0] rb;
    } script_row_t;

    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{css_pkg::CMD_EOL,  8'h00, 1'b1, 1'b1,
          css_pkg::KIND_EOL,  1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, 8'h00, 1'b1, 1'b1,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, 8'hFF, 1'b1, 1'b1,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'hFF},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b1,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, css_pkg::CH_SLASH},
        '{css_pkg::CMD_TEXT, 8'h78, 1'b0, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b1, 1'b1,
          css_pkg::KIND_EOL,  1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SPACE, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_TAB, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b0, 1'b0,
          css_pkg::KIND_EOL,  1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SPACE, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_STAR, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, 8'h71, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b1, 1'b1,
          css_pkg::KIND_EOL,  1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_STAR, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b1, 1'b1,
          css_pkg::KIND_EOL,  1'b0, 1'b1, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_STAR, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, 8'h62, 1'b1, 1'b1,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h62},
        '{css_pkg::CMD_TEXT, css_pkg::CH_QUOTE, 1'b0, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b0, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_QUOTE, 1'b0, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SPACE, 1'b0, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b1, 1'b1,
          css_pkg::KIND_EOL,  1'b1, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_TEXT, css_pkg::CH_SLASH, 1'b1, 1'b0,
          css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0, 8'h00},
        '{css_pkg::CMD_EOL,  8'h00, 1'b0, 1'b0,
          css_pkg::KIND_EOL,  1'b0, 1'b0, 1'b0, 8'h00}
    };

    logic clk = 1'b0;
    logic rst_n;

    css_text_if   text_ch();
    css_result_if result_ch();

    comment_stripper_stream #(.MAX_LEAD(LEAD_DEPTH)) DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .text_ch   (text_ch),
        .result_ch (result_ch)
    );

    always #5 clk = ~clk;

    // stripper state as seen by the bench
    logic       blk_open     = 1'b0;
    logic       blk_star     = 1'b0;
    logic       str_open     = 1'b0;
    logic [1:0] line_ph      = css_pkg::PH_LEAD;
    logic       slash_held   = 1'b0;
    logic       slash_counts = 1'b0;
    logic       last_blank   = 1'b1;
    logic       cont_seen    = 1'b0;
    int         lead_n       = 0;
    logic       lead_is_tab [LEAD_DEPTH];
    logic       lead_ovf     = 1'b0;

    strip_res_t step_out[$];
    strip_res_t typed_out[$];
    strip_res_t stripped_q[$];
    logic [7:0] line_q[$];

    int mismatches    = 0;
    bit calm          = 1'b0;
    int hold_asks     = 0;
    int holds_granted = 0;
    int stall_left    = 0;

    function automatic void add_byte(logic [7:0] b);
        line_q.insert(line_q.size(), b);
    endfunction

    function automatic void add_typed(strip_res_t r);
        typed_out.insert(typed_out.size(), r);
    endfunction

    function automatic void add_expected(strip_res_t r);
        stripped_q.insert(stripped_q.size(), r);
    endfunction

    function automatic void emit(logic [7:0] b, logic k, logic c, logic o, logic v);
        strip_res_t r;
        r = '{out_byte: b, kind: k, continued: c, comment_open: o,
              lead_overflow: v, last: 1'b0};
        if (step_out.size() < RES_CAP)
            step_out.insert(step_out.size(), r);
    endfunction

    function automatic void flush_lead();
        for (int k = 0; k < lead_n; k++)
            emit(lead_is_tab[k] ? css_pkg::CH_TAB : css_pkg::CH_SPACE,
                 css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
        lead_n = 0;
    endfunction

    function automatic void take_plain(logic [7:0] c);
        if (c == css_pkg::CH_QUOTE)
        begin
            emit(c, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
            str_open = 1'b1;
        end
        else if (c == css_pkg::CH_SLASH)
        begin
            slash_held   = 1'b1;
            slash_counts = last_blank;
        end
        else
            emit(c, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
        last_blank = (c == css_pkg::CH_SPACE || c == css_pkg::CH_TAB);
    endfunction

    function automatic void take_text(logic [7:0] c);
        logic blank;
        blank = (c == css_pkg::CH_SPACE || c == css_pkg::CH_TAB);
        if (blk_open)
        begin
            if (blk_star && c == css_pkg::CH_SLASH)
            begin
                blk_open = 1'b0;
                blk_star = 1'b0;
                line_ph  = css_pkg::PH_NORMAL;
            end
            else
                blk_star = (c == css_pkg::CH_STAR);
            last_blank = blank;
            return;
        end
        if (line_ph == css_pkg::PH_DROP)
            return;
        if (line_ph == css_pkg::PH_AFTER2)
        begin
            if (c == css_pkg::CH_SLASH)
                cont_seen = 1'b1;
            line_ph = css_pkg::PH_DROP;
            return;
        end
        if (line_ph == css_pkg::PH_LEAD)
        begin
            if (blank)
            begin
                if (lead_n < LEAD_DEPTH)
                begin
                    lead_is_tab[lead_n] = (c == css_pkg::CH_TAB);
                    lead_n++;
                end
                else
                    lead_ovf = 1'b1;
                last_blank = 1'b1;
                return;
            end
            if (c == css_pkg::CH_STAR)
            begin
                lead_n  = 0;
                line_ph = css_pkg::PH_DROP;
                return;
            end
            flush_lead();
            line_ph = css_pkg::PH_NORMAL;
        end
        if (str_open)
        begin
            emit(c, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
            if (c == css_pkg::CH_QUOTE)
                str_open = 1'b0;
            last_blank = blank;
            return;
        end
        if (slash_held)
        begin
            if (c == css_pkg::CH_STAR)
            begin
                slash_held = 1'b0;
                blk_open   = 1'b1;
                blk_star   = 1'b0;
                last_blank = 1'b0;
                return;
            end
            if (c == css_pkg::CH_SLASH)
            begin
                if (slash_counts)
                begin
                    slash_held = 1'b0;
                    line_ph    = css_pkg::PH_AFTER2;
                end
                else
                begin
                    // slashes after a non-blank stay as text, the second one held
                    emit(css_pkg::CH_SLASH, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
                    slash_counts = 1'b0;
                end
                last_blank = 1'b0;
                return;
            end
            emit(css_pkg::CH_SLASH, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
            slash_held = 1'b0;
            last_blank = 1'b0;
        end
        take_plain(c);
    endfunction

    function automatic void take_eol();
        if (!blk_open)
        begin
            if (line_ph == css_pkg::PH_LEAD)
                flush_lead();
            if (line_ph == css_pkg::PH_NORMAL && slash_held)
                emit(css_pkg::CH_SLASH, css_pkg::KIND_BYTE, 1'b0, 1'b0, 1'b0);
        end
        emit(8'h00, css_pkg::KIND_EOL, cont_seen, blk_open, lead_ovf);
        str_open     = 1'b0;
        blk_star     = 1'b0;
        slash_held   = 1'b0;
        slash_counts = 1'b0;
        last_blank   = 1'b1;
        cont_seen    = 1'b0;
        lead_n       = 0;
        lead_ovf     = 1'b0;
        line_ph      = css_pkg::PH_LEAD;
    endfunction

    function automatic void strip_request(logic c, logic [7:0] b);
        step_out.delete();
        if (c == css_pkg::CMD_EOL)
            take_eol();
        else
            take_text(b);
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_junk();
        case ($urandom_range(5))
            0:       return css_pkg::CH_SLASH;
            1:       return css_pkg::CH_STAR;
            2:       return css_pkg::CH_SPACE;
            3:       return css_pkg::CH_TAB;
            4:       return css_pkg::CH_QUOTE;
            default: return 8'($urandom_range(97, 122));
        endcase
    endfunction

    // lead < 0, ntok < 0, star < 0: chosen at random
    function automatic void build_line(int lead, int ntok, int star);
        int n;
        int r;
        line_q.delete();
        if (lead < 0)
        begin
            r    = $urandom_range(99);
            lead = (r < 55) ? 0 : (r < 98) ? $urandom_range(1, 6) : $urandom_range(58, 66);
        end
        repeat (lead)
            add_byte($urandom_range(1) ? css_pkg::CH_TAB : css_pkg::CH_SPACE);
        if (star > 0 || (star < 0 && $urandom_range(9) == 0))
            add_byte(css_pkg::CH_STAR);
        if (ntok < 0)
            ntok = $urandom_range(1, 5);
        repeat (ntok)
        begin
            case ($urandom_range(7))
                0:
                    repeat ($urandom_range(1, 4))
                        add_byte(8'($urandom_range(97, 122)));
                1:
                    repeat ($urandom_range(1, 2))
                        add_byte(8'($urandom_range(255)));
                2:
                    add_byte($urandom_range(1) ? css_pkg::CH_TAB : css_pkg::CH_SPACE);
                3:
                begin
                    add_byte(css_pkg::CH_QUOTE);
                    repeat ($urandom_range(3))
                        add_byte(pick_junk());
                    if ($urandom_range(3) != 0)
                        add_byte(css_pkg::CH_QUOTE);
                end
                4:
                begin
                    if ($urandom_range(1))
                        add_byte(css_pkg::CH_SPACE);
                    add_byte(css_pkg::CH_SLASH);
                    add_byte(css_pkg::CH_SLASH);
                    if ($urandom_range(1))
                        add_byte(css_pkg::CH_SLASH);
                    repeat ($urandom_range(3))
                        add_byte(pick_junk());
                end
                5:
                begin
                    add_byte(css_pkg::CH_SLASH);
                    add_byte(css_pkg::CH_STAR);
                    repeat ($urandom_range(3))
                        add_byte(pick_junk());
                end
                6:
                begin
                    add_byte(css_pkg::CH_STAR);
                    add_byte(css_pkg::CH_SLASH);
                end
                default:
                    add_byte(css_pkg::CH_SLASH);
            endcase
        end
    endfunction

    task automatic send_request(input logic c, input logic [7:0] b, input bit use_typed);
        text_ch.valid     <= 1'b1;
        text_ch.cmd       <= c;
        text_ch.text_byte <= b;
        do
            @(posedge clk);
        while (!text_ch.ready);
        strip_request(c, b);
        if (use_typed)
            step_out = typed_out;
        foreach (step_out[i])
            add_expected(step_out[i]);
        if (!calm && $urandom_range(99) < 9)
        begin
            text_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3))
                @(posedge clk);
        end
    endtask

    task automatic send_line(inout int sent);
        foreach (line_q[i])
            send_request(css_pkg::CMD_TEXT, line_q[i], 1'b0);
        send_request(css_pkg::CMD_EOL, 8'($urandom_range(255)), 1'b0);
        sent += line_q.size() + 1;
    endtask

    function automatic void check_result();
        strip_res_t got;
        strip_res_t want;
        got = '{out_byte: result_ch.out_byte, kind: result_ch.kind,
                continued: result_ch.continued, comment_open: result_ch.comment_open,
                lead_overflow: result_ch.lead_overflow, last: result_ch.last};
        if (stripped_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: unexpected result, expected none, got byte %02h kind %0b",
                     $time, got.out_byte, got.kind);
            return;
        end
        want = stripped_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: expected byte %02h kind %0b cont %0b open %0b ovf %0b last %0b",
                     $time, want.out_byte, want.kind, want.continued,
                     want.comment_open, want.lead_overflow, want.last);
            $display("%0t: actual   byte %02h kind %0b cont %0b open %0b ovf %0b last %0b",
                     $time, got.out_byte, got.kind, got.continued,
                     got.comment_open, got.lead_overflow, got.last);
        end
    endfunction

    // receiver: checks, random idling, long hold-off on request
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
                check_result();
            if (holds_granted != hold_asks)
            begin
                holds_granted = hold_asks;
                stall_left    = STALL_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= calm || ($urandom_range(99) >= 15);
        end
    end

    initial
    begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        int   sent;
        int   line_no;
        logic c;

        sent               = 0;
        line_no            = 0;
        rst_n              = 1'b0;
        text_ch.valid      = 1'b0;
        text_ch.cmd        = css_pkg::CMD_TEXT;
        text_ch.text_byte  = 8'h00;
        result_ch.ready    = 1'b0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (SCRIPT[i])
        begin
            typed_out.delete();
            if (SCRIPT[i].has_res)
                add_typed('{out_byte: SCRIPT[i].rb, kind: SCRIPT[i].rk,
                            continued: SCRIPT[i].rc, comment_open: SCRIPT[i].ro,
                            lead_overflow: SCRIPT[i].rv, last: 1'b1});
            send_request(SCRIPT[i].cmd, SCRIPT[i].ch, SCRIPT[i].typed);
        end
        sent = SCRIPT_LEN;

        while (sent < RAND_ITEMS)
        begin
            line_no++;
            calm = (line_no >= 30 && line_no < 45);
            if (line_no == 15)
                hold_asks++;
            if (line_no == 25)
            begin
                // sender pause: let every result drain
                text_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (stripped_q.size() != 0);
            end
            if (line_no == 3)
            begin
                build_line(LEAD_DEPTH, 0, 0);
                send_line(sent);
            end
            else if (line_no == 8)
            begin
                build_line(LEAD_DEPTH + 3, -1, 0);
                send_line(sent);
            end
            else if (line_no == 12)
            begin
                build_line(LEAD_DEPTH + 2, 2, 1);
                send_line(sent);
            end
            else if ($urandom_range(9) == 0)
            begin
                // raw noise
                repeat ($urandom_range(2, 8))
                begin
                    c = ($urandom_range(7) == 0) ? css_pkg::CMD_EOL : css_pkg::CMD_TEXT;
                    send_request(c, 8'($urandom_range(255)), 1'b0);
                    sent++;
                end
            end
            else
            begin
                build_line(-1, -1, -1);
                send_line(sent);
            end
        end
        calm = 1'b0;
        text_ch.valid <= 1'b0;

        while (stripped_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
